// ===== hdl/spc_pkg.sv =====
package spc_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int TABLE_ADDR_BITS     = 8;
   localparam int LUT_N               = 1 << TABLE_ADDR_BITS;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // dB per octave and octaves per dB, fixed point
   localparam logic [31:0] DB_PER_LOG2_Q32 = 32'd101008905;
   localparam logic [31:0] LOG2_PER_DB_Q16 = 32'd2786635;
   localparam logic [30:0] ONE_Q30         = 31'h4000_0000;

   localparam logic signed [15:0] THRESHOLD_RESET = -16'sd5120;
   localparam logic [15:0] RATIO_RESET   = 16'd32768;
   localparam logic [15:0] ATTACK_RESET  = 16'd65399;
   localparam logic [15:0] RELEASE_RESET = 16'd65522;
   localparam logic [15:0] MAKEUP_RESET  = 16'd4096;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_THRESHOLD,
      CSR_RATIO,
      CSR_ATTACK,
      CSR_RELEASE,
      CSR_MAKEUP,
      CSR_MODE
   } csr_index_type;

   typedef enum logic [4:0] {
      STEP_IDLE,
      STEP_ENV_A,
      STEP_ENV_B,
      STEP_ENV_WAIT,
      STEP_LOG_PREP,
      STEP_LOG_MUL,
      STEP_LOG_WAIT,
      STEP_DB_MUL,
      STEP_DB_WAIT,
      STEP_GR_MUL,
      STEP_GR_WAIT,
      STEP_L2_MUL,
      STEP_L2_WAIT,
      STEP_EXP_PREP,
      STEP_EXP_MUL,
      STEP_EXP_WAIT,
      STEP_MK_MUL,
      STEP_MK_WAIT,
      STEP_LLO,
      STEP_LHI,
      STEP_RLO,
      STEP_RHI,
      STEP_OUT_WAIT
   } step_type;

   typedef struct packed {
      step_type step;
      logic     load_in;
      logic     load_out;
   } cmd_type;

   typedef logic [16:0] log_tbl_type [0:LUT_N];
   typedef logic [30:0] exp_tbl_type [0:LUT_N];

   // log2(1 + i/N) in Q16 by repeated squaring, kept monotonic
   function automatic log_tbl_type build_log_tbl();
      log_tbl_type t;
      logic [63:0] x;
      logic [16:0] y;
      for (int i = 0; i < LUT_N; i++) begin
         x = 64'(LUT_N + i) << (30 - TABLE_ADDR_BITS);
         y = '0;
         for (int k = 15; k >= 0; k--) begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30)) begin
               x = x >> 1;
               y[k] = 1'b1;
            end
         end
         if (i > 0 && y < t[i-1]) begin
            y = t[i-1];
         end
         t[i] = y;
      end
      t[LUT_N] = 17'd65536;
      return t;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] b;
      x = v;
      r = '0;
      b = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 2^(-i/N) in Q1.30 from products of repeated square roots of one half
   function automatic exp_tbl_type build_exp_tbl();
      exp_tbl_type t;
      logic [63:0] roots [TABLE_ADDR_BITS];
      logic [63:0] s;
      logic [63:0] p;
      s = 64'd1 << 29;
      for (int k = 0; k < TABLE_ADDR_BITS; k++) begin
         s = isqrt64(s << 30);
         roots[k] = s;
      end
      for (int i = 0; i < LUT_N; i++) begin
         p = 64'd1 << 30;
         for (int k = 0; k < TABLE_ADDR_BITS; k++) begin
            if (((i >> (TABLE_ADDR_BITS - 1 - k)) & 1) != 0) begin
               p = (p * roots[k]) >> 30;
            end
         end
         if (i > 0 && 31'(p) > t[i-1]) begin
            t[i] = t[i-1];
         end else begin
            t[i] = 31'(p);
         end
      end
      t[LUT_N] = 31'h2000_0000;
      return t;
   endfunction

   localparam log_tbl_type LOG_TBL = build_log_tbl();
   localparam exp_tbl_type EXP_TBL = build_exp_tbl();

endpackage

// ===== hdl/spc_ctrl.sv =====
module spc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output spc_pkg::cmd_type  cmd
);
   import spc_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_type;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      load_out;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign load_out  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.step     = (state_ff == ST_RUN) ? step_ff : STEP_IDLE;
      cmd.load_in  = accept;
      cmd.load_out = load_out;
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               step_in  = STEP_ENV_A;
            end
         end
         ST_RUN: begin
            if (step_ff == STEP_OUT_WAIT) begin
               state_in = ST_DONE;
               step_in  = STEP_IDLE;
            end else begin
               step_in = step_type'(step_ff + 5'd1);
            end
         end
         ST_DONE: begin
            if (load_out) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // never overwrite a result that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register loaded while still holding a result");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_RUN && step_ff == STEP_ENV_A))
      else $error("accepted frame did not start the sequence");

   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(load_out))
      else $error("result valid raised without a load");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("ready while a frame is in work");

endmodule

// ===== hdl/spc_datapath.sv =====
module spc_datapath #(
   parameter int SAMPLE_BITS = spc_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  spc_pkg::cmd_type        cmd,
   input  logic [SAMPLE_BITS-1:0]  left_sample,
   input  logic [SAMPLE_BITS-1:0]  right_sample,
   input  logic                    block_end,
   input  logic signed [15:0]      threshold_db,
   input  logic [15:0]             ratio_slope,
   input  logic [15:0]             attack_coef,
   input  logic [15:0]             release_coef,
   input  logic [15:0]             makeup_gain,
   input  logic                    stereo,
   output logic [SAMPLE_BITS-1:0]  left_out,
   output logic [SAMPLE_BITS-1:0]  right_out,
   output logic                    frame_last
);
   import spc_pkg::*;

   localparam int SB     = SAMPLE_BITS;
   localparam int LVL_SH = 24 - SB;
   localparam int AW     = TABLE_ADDR_BITS;
   localparam int LFR    = 23 - AW;
   localparam int EFR    = 16 - AW;
   localparam logic [29:0] HI    = (30'd1 << (SB - 1)) - 30'd1;
   localparam logic [29:0] HI_P1 = 30'd1 << (SB - 1);

   function automatic logic [SB-1:0] saturate(input logic neg, input logic [29:0] r);
      logic [29:0] rr;
      if (neg) begin
         rr = (r > HI_P1) ? HI_P1 : r;
         saturate = SB'(30'd0 - rr);
      end else begin
         rr = (r > HI) ? HI : r;
         saturate = SB'(rr);
      end
   endfunction

   // frame registers
   logic [SB-1:0] mag_l_ff, mag_r_ff;
   logic          neg_l_ff, neg_r_ff, stereo_ff, last_ff;
   logic [23:0]   level_ff;
   logic [15:0]   coef_ff;
   logic [23:0]   env_ff;

   // working registers
   step_type      last_step_ff;
   logic [63:0]   prod_ff;
   logic [47:0]   acc_ff;
   logic [20:0]   lbase_ff;
   logic [16:0]   dlog_ff;
   logic [LFR-1:0] lrem_ff;
   logic [20:0]   t_ff;
   logic          above_ff;
   logic [16:0]   over_ff;
   logic [16:0]   gr_ff;
   logic [22:0]   l2_ff;
   logic [30:0]   ebase_ff, dexp_ff;
   logic [EFR-1:0] erem_ff;
   logic          deep_ff;
   logic [4:0]    nsh_ff;
   logic [30:0]   gain_ff;
   logic [34:0]   g_ff;
   logic [SB-1:0] lo_ff, ro_ff;
   logic [SB-1:0] left_out_ff, right_out_ff;
   logic          frame_last_ff;

   // accept-time detector
   logic [SB-1:0] mag_l, mag_r, pk;
   logic [23:0]   level;

   always_comb begin
      mag_l = left_sample[SB-1]  ? (SB'(0) - left_sample)  : left_sample;
      mag_r = right_sample[SB-1] ? (SB'(0) - right_sample) : right_sample;
      pk    = (stereo && (mag_r > mag_l)) ? mag_r : mag_l;
      level = 24'(pk) << LVL_SH;
   end

   // shared multiplier operands
   logic [31:0] mul_a, mul_b;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.step)
         STEP_ENV_A: begin
            mul_a = 32'(coef_ff);
            mul_b = 32'(env_ff);
         end
         STEP_ENV_B: begin
            mul_a = 32'(17'h1_0000 - {1'b0, coef_ff});
            mul_b = 32'(level_ff);
         end
         STEP_LOG_MUL: begin
            mul_a = 32'(dlog_ff);
            mul_b = 32'(lrem_ff);
         end
         STEP_DB_MUL: begin
            mul_a = 32'(t_ff);
            mul_b = DB_PER_LOG2_Q32;
         end
         STEP_GR_MUL: begin
            mul_a = 32'(over_ff);
            mul_b = 32'(ratio_slope);
         end
         STEP_L2_MUL: begin
            mul_a = 32'(gr_ff);
            mul_b = LOG2_PER_DB_Q16;
         end
         STEP_EXP_MUL: begin
            mul_a = 32'(dexp_ff);
            mul_b = 32'(erem_ff);
         end
         STEP_MK_MUL: begin
            mul_a = 32'(gain_ff);
            mul_b = 32'(makeup_gain);
         end
         STEP_LLO: begin
            mul_a = 32'(mag_l_ff);
            mul_b = 32'(g_ff[17:0]);
         end
         STEP_LHI: begin
            mul_a = 32'(mag_l_ff);
            mul_b = 32'(g_ff[34:18]);
         end
         STEP_RLO: begin
            mul_a = 32'(mag_r_ff);
            mul_b = 32'(g_ff[17:0]);
         end
         STEP_RHI: begin
            mul_a = 32'(mag_r_ff);
            mul_b = 32'(g_ff[34:18]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // log table lookup: leading one, mantissa split
   logic [23:0]   lx, lsh;
   logic [4:0]    lpos;
   logic [AW-1:0] lidx;

   always_comb begin
      lx   = (env_ff == '0) ? 24'd1 : env_ff;
      lpos = '0;
      for (int i = 0; i < 24; i++) begin
         if (lx[i]) begin
            lpos = 5'(i);
         end
      end
      lsh  = lx << (5'd23 - lpos);
      lidx = lsh[22:LFR];
   end

   // exp table lookup
   logic [AW-1:0] eidx;
   assign eidx = l2_ff[15:EFR];

   // post-processing of the previous product
   logic [48:0]        env_sum;
   logic [21:0]        lg;
   logic signed [17:0] env_db, thr18, diff;
   logic [30:0]        e_val;
   logic [59:0]        full;

   always_comb begin
      env_sum = 49'(acc_ff) + 49'(prod_ff[47:0]);
      lg      = 22'(lbase_ff) + 22'(prod_ff >> LFR);
      if (lg > (22'd23 << 16)) begin
         lg = 22'd23 << 16;
      end
      env_db  = 18'sd0 - $signed({1'b0, prod_ff[48:32]});
      thr18   = 18'(threshold_db);
      diff    = env_db - thr18;
      e_val   = ebase_ff - 31'(prod_ff >> EFR);
      full    = 60'(acc_ff) + (60'(prod_ff[41:0]) << 18);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff       <= '0;
         last_step_ff <= STEP_IDLE;
      end else begin
         last_step_ff <= cmd.step;
         if (last_step_ff == STEP_ENV_B) begin
            env_ff <= env_sum[39:16];
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;

      if (cmd.load_in) begin
         mag_l_ff  <= mag_l;
         mag_r_ff  <= mag_r;
         neg_l_ff  <= left_sample[SB-1];
         neg_r_ff  <= right_sample[SB-1];
         stereo_ff <= stereo;
         last_ff   <= block_end;
         level_ff  <= level;
         coef_ff   <= (level > env_ff) ? attack_coef : release_coef;
      end

      case (cmd.step)
         STEP_LOG_PREP: begin
            lbase_ff <= (21'(lpos) << 16) + 21'(LOG_TBL[{1'b0, lidx}]);
            dlog_ff  <= LOG_TBL[{1'b0, lidx} + (AW+1)'(1)] - LOG_TBL[{1'b0, lidx}];
            lrem_ff  <= lsh[LFR-1:0];
         end
         STEP_EXP_PREP: begin
            ebase_ff <= EXP_TBL[{1'b0, eidx}];
            dexp_ff  <= EXP_TBL[{1'b0, eidx}] - EXP_TBL[{1'b0, eidx} + (AW+1)'(1)];
            erem_ff  <= l2_ff[EFR-1:0];
            deep_ff  <= (l2_ff[22:16] > 7'd30);
            nsh_ff   <= l2_ff[20:16];
         end
         default: begin
         end
      endcase

      case (last_step_ff)
         STEP_ENV_A:   acc_ff <= prod_ff[47:0];
         STEP_LOG_MUL: t_ff   <= 21'((22'd23 << 16) - lg);
         STEP_DB_MUL: begin
            above_ff <= (env_db > thr18);
            over_ff  <= diff[16:0];
         end
         STEP_GR_MUL:  gr_ff <= prod_ff[32:16];
         STEP_L2_MUL:  l2_ff <= prod_ff[38:16];
         STEP_EXP_MUL: begin
            if (!above_ff) begin
               gain_ff <= ONE_Q30;
            end else if (deep_ff) begin
               gain_ff <= '0;
            end else begin
               gain_ff <= e_val >> nsh_ff;
            end
         end
         STEP_MK_MUL:  g_ff   <= prod_ff[46:12];
         STEP_LLO:     acc_ff <= prod_ff[47:0];
         STEP_LHI:     lo_ff  <= saturate(neg_l_ff, full[59:30]);
         STEP_RLO:     acc_ff <= prod_ff[47:0];
         STEP_RHI:     ro_ff  <= stereo_ff ? saturate(neg_r_ff, full[59:30]) : '0;
         default: begin
         end
      endcase

      if (cmd.load_out) begin
         left_out_ff   <= lo_ff;
         right_out_ff  <= ro_ff;
         frame_last_ff <= last_ff;
      end
   end

   assign left_out   = left_out_ff;
   assign right_out  = right_out_ff;
   assign frame_last = frame_last_ff;

endmodule

// ===== hdl/stereo_peak_compressor_unit.sv =====
// Feed-forward stereo peak compressor. Each frame transfer on req_ carries a
// left and right sample; one result transfer on rsp_ returns the gain-scaled,
// saturated samples plus the block_end mark. One shared 32x32 multiplier is
// stepped through the envelope smoother, log table, dB slope, exp table,
// makeup gain and per-channel scaling. A frame's result goes valid once its
// transfer has run through 22 sequencer steps and the result register has
// been loaded; req_ready returns together with rsp_valid after that load, so
// no new frame transfers before the previous one is loaded. The next frame is
// accepted while the previous result is still waiting on rsp_ready; its own
// load then stalls until that result is taken. Configuration writes on csr_
// take effect at once and must only be issued while no frame is in work. Mono
// mode (CSR_MODE bit 0 cleared) detects on the left sample only and forces
// rsp_right_out to zero.
module stereo_peak_compressor_unit #(
   parameter int SAMPLE_BITS = spc_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [SAMPLE_BITS-1:0]      req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0]      req_right_sample,
   input  logic                               req_block_end,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]      rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]      rsp_right_out,
   output logic                               rsp_frame_last,
   input  logic                               csr_write_en,
   input  logic [spc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [spc_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import spc_pkg::*;

   // configuration registers
   logic signed [15:0] threshold_ff;
   logic [15:0]        ratio_ff, attack_ff, release_ff, makeup_ff;
   logic               mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         ratio_ff     <= RATIO_RESET;
         attack_ff    <= ATTACK_RESET;
         release_ff   <= RELEASE_RESET;
         makeup_ff    <= MAKEUP_RESET;
         mode_ff      <= 1'b1;
      end else if (csr_write_en) begin
         // unknown indexes are dropped
         case (csr_index)
            CSR_THRESHOLD: threshold_ff <= $signed(csr_data);
            CSR_RATIO:     ratio_ff     <= csr_data;
            CSR_ATTACK:    attack_ff    <= csr_data;
            CSR_RELEASE:   release_ff   <= csr_data;
            CSR_MAKEUP:    makeup_ff    <= csr_data;
            CSR_MODE:      mode_ff      <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   cmd_type cmd;
   logic [SAMPLE_BITS-1:0] left_q, right_q;

   // sequencer: accept, step the shared multiplier, hand off to result reg
   spc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   spc_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .left_sample  (req_left_sample),
      .right_sample (req_right_sample),
      .block_end    (req_block_end),
      .threshold_db (threshold_ff),
      .ratio_slope  (ratio_ff),
      .attack_coef  (attack_ff),
      .release_coef (release_ff),
      .makeup_gain  (makeup_ff),
      .stereo       (mode_ff),
      .left_out     (left_q),
      .right_out    (right_q),
      .frame_last   (rsp_frame_last)
   );

   assign rsp_left_out  = $signed(left_q);
   assign rsp_right_out = $signed(right_q);

endmodule
